>>> rtl/local_alignment_orientation_macros.svh
// assertion macros for the local alignment orientation block
// used by the port checker; no other dependencies
`ifndef LOCAL_ALIGNMENT_ORIENTATION_MACROS_SVH
`define LOCAL_ALIGNMENT_ORIENTATION_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define LAO_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lao check failed");

// next-cycle implication
`define LAO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lao check failed");

`endif

>>> rtl/lao_pkg.sv
// shared types, codes and defaults of the local alignment orientation block
// no dependencies
`default_nettype none

package lao_pkg;

  localparam int unsigned MaxLen     = 512;
  localparam int unsigned SymbolBits = 8;

  localparam logic [7:0] MatchReset    = 8'h02;
  localparam logic [7:0] MismatchReset = 8'hFF;
  localparam logic [7:0] GapReset      = 8'hFE;

  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;

  localparam logic [1:0] ORIENT_NEG  = 2'd0;
  localparam logic [1:0] ORIENT_ZERO = 2'd1;
  localparam logic [1:0] ORIENT_POS  = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_ALIGN         = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    DIR_ZERO = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DIAG = 2'd2,
    DIR_LEFT = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FILL,
    ST_REDUCE,
    ST_TRACE_RD,
    ST_TRACE_ST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
  } req_t;

  typedef struct packed {
    logic [15:0] best_score;
    logic [1:0]  orientation;
    logic        truncated;
  } res_t;

  typedef struct packed {
    logic [7:0] match_score;
    logic [7:0] mismatch_score;
    logic [7:0] gap_score;
  } score_cfg_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic fill;
    logic reduce;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lao_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module lao_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lao_cell.sv
// one column cell of the alignment array: holds a second-read symbol, its score
// column entry and its column best; uses lao_pkg
`default_nettype none

module lao_cell #(
  parameter int unsigned SYMBOL_BITS = 8,
  parameter int unsigned ROW_W       = 10,
  parameter int unsigned COL         = 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lao_pkg::cell_ctl_t     ctl_i,
  input  wire lao_pkg::score_cfg_t    cfg_i,
  input  wire logic [ROW_W-1:0]       len_i,
  input  wire logic [SYMBOL_BITS-1:0] sym_i,
  input  wire logic [SYMBOL_BITS-1:0] a_i,
  input  wire logic                   v_i,
  input  wire logic [ROW_W-1:0]       r_i,
  input  wire logic [15:0]            h_i,
  input  wire logic [15:0]            dg_i,
  input  wire logic                   cv_i,
  input  wire logic [15:0]            cs_i,
  input  wire logic [ROW_W-1:0]       cr_i,
  input  wire logic [ROW_W-1:0]       cc_i,
  output logic [SYMBOL_BITS-1:0]      a_o,
  output logic                        v_o,
  output logic [ROW_W-1:0]            r_o,
  output logic [15:0]                 h_o,
  output logic [15:0]                 dg_o,
  output logic                        cv_o,
  output logic [15:0]                 cs_o,
  output logic [ROW_W-1:0]            cr_o,
  output logic [ROW_W-1:0]            cc_o,
  output logic [1:0]                  dir_o
);

  logic [SYMBOL_BITS-1:0] b_q, a_q;
  logic                   v_q, ov_q, cv_q;
  logic [ROW_W-1:0]       r_q, br_q, cr_q, cc_q;
  logic [15:0]            h_q, dg_q, bs_q, cs_q;
  lao_pkg::dir_e          dir_q, dir_d;

  logic signed [17:0] gap_x, sub_x, up_s, dg_s, lf_s, best_s;
  logic [15:0]        h_new;
  logic               active, upd_best, take;

  assign active = (len_i >= ROW_W'(COL));
  assign gap_x  = {{10{cfg_i.gap_score[7]}}, cfg_i.gap_score};
  assign sub_x  = (a_i == b_q) ? {{10{cfg_i.match_score[7]}}, cfg_i.match_score}
                               : {{10{cfg_i.mismatch_score[7]}}, cfg_i.mismatch_score};
  assign up_s   = $signed({2'b00, h_i}) + gap_x;
  assign dg_s   = $signed({2'b00, dg_i}) + sub_x;
  assign lf_s   = $signed({2'b00, h_q}) + gap_x;

  // ties keep the earlier choice: zero, up, diagonal, left
  always_comb begin
    best_s = '0;
    dir_d  = lao_pkg::DIR_ZERO;
    if (up_s > best_s) begin
      best_s = up_s;
      dir_d  = lao_pkg::DIR_UP;
    end
    if (dg_s > best_s) begin
      best_s = dg_s;
      dir_d  = lao_pkg::DIR_DIAG;
    end
    if (lf_s > best_s) begin
      best_s = lf_s;
      dir_d  = lao_pkg::DIR_LEFT;
    end
  end

  assign h_new    = (best_s > 18'sd65535) ? 16'hFFFF : best_s[15:0];
  assign upd_best = ctl_i.fill && v_i && active && (!ov_q || (h_new >= bs_q));
  // later column wins a tie on score and row
  assign take     = ov_q && (!cv_i || (bs_q > cs_i) || ((bs_q == cs_i) && (br_q >= cr_i)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      ov_q <= 1'b0;
      cv_q <= 1'b0;
    end else if (ctl_i.clear) begin
      v_q  <= 1'b0;
      ov_q <= 1'b0;
      cv_q <= 1'b0;
    end else begin
      v_q <= ctl_i.fill && v_i;
      if (upd_best) begin
        ov_q <= 1'b1;
      end
      if (ctl_i.reduce) begin
        cv_q <= take || cv_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && (len_i == ROW_W'(COL - 1))) begin
      b_q <= sym_i;
    end
    a_q   <= a_i;
    r_q   <= r_i;
    dir_q <= dir_d;
    if (ctl_i.clear) begin
      h_q  <= '0;
      dg_q <= '0;
    end else if (ctl_i.fill && v_i) begin
      h_q  <= h_new;
      dg_q <= h_q;
    end
    if (upd_best) begin
      bs_q <= h_new;
      br_q <= r_i;
    end
    if (ctl_i.reduce) begin
      cs_q <= take ? bs_q : cs_i;
      cr_q <= take ? br_q : cr_i;
      cc_q <= take ? ROW_W'(COL) : cc_i;
    end
  end

  assign a_o   = a_q;
  assign v_o   = v_q;
  assign r_o   = r_q;
  assign h_o   = h_q;
  assign dg_o  = dg_q;
  assign cv_o  = cv_q;
  assign cs_o  = cs_q;
  assign cr_o  = cr_q;
  assign cc_o  = cc_q;
  assign dir_o = dir_q;

endmodule

`default_nettype wire

>>> rtl/local_alignment_orientation.sv
// local alignment orientation top level: command port, apb registers, read
// storage, cell chain and traceback; uses lao_pkg, lao_ram, lao_cell
//
// channel   direction  handshake                      payload
// command   in         start && !busy                 req_i (operation, symbol)
// result    out        done_o, one cycle, no stall    res_o (best_score, orientation,
//                                                     truncated)
// config    in         apb write, pready always high  match, mismatch, gap scores
//
// appends are taken while idle and the block stays ready.
// an align request holds busy through a clear state, the fill through the cell
// chain, best-cell reduction along the chain, traceback steps that each read the
// direction ram (registered read) and then step, a final check, then the result
// state.
// asynchronous active-low reset; results cannot be stalled by the receiver.
`default_nettype none

module local_alignment_orientation #(
  parameter int unsigned MAX_LEN     = lao_pkg::MaxLen,
  parameter int unsigned SYMBOL_BITS = lao_pkg::SymbolBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire lao_pkg::req_t req_i,
  output logic             done_o,
  output lao_pkg::res_t    res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned RW = $clog2(MAX_LEN + 1);
  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned AW = $clog2(2 * MAX_LEN + 1);
  localparam int unsigned DW = 2 * MAX_LEN;

  lao_pkg::state_e     state_q, state_d;
  lao_pkg::score_cfg_t cfg_q;
  lao_pkg::cell_ctl_t  ctl;

  logic [RW-1:0] len1_q, len1_d, len2_q, len2_d;
  logic          drop_q, drop_d;
  logic [AW-1:0] fc_q, fc_d, len_sum;
  logic [RW-1:0] rc_q, rc_d;
  logic          inj_v_q, inj_v_d;
  logic [RW-1:0] inj_r_q, inj_r_d;
  logic [RW-1:0] ti_q, ti_d, tj_q, tj_d, tj_m1;
  logic [15:0]   best_q, best_d;

  logic accept, cfg_wr, first_we, dir_we;
  logic [SYMBOL_BITS-1:0] sym_in, first_rd;
  logic [DW-1:0] dir_row, dir_rd;
  lao_pkg::dir_e step_dir;

  logic [SYMBOL_BITS-1:0] a_w  [MAX_LEN+1];
  logic                   v_w  [MAX_LEN+1];
  logic [RW-1:0]          r_w  [MAX_LEN+1];
  logic [15:0]            h_w  [MAX_LEN+1];
  logic [15:0]            dg_w [MAX_LEN+1];
  logic                   cv_w [MAX_LEN+1];
  logic [15:0]            cs_w [MAX_LEN+1];
  logic [RW-1:0]          cr_w [MAX_LEN+1];
  logic [RW-1:0]          cc_w [MAX_LEN+1];

  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign sym_in  = req_i.symbol[SYMBOL_BITS-1:0];
  assign len_sum = AW'(len1_q) + AW'(len2_q);
  assign pready  = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      lao_pkg::REG_MATCH:    prdata = {{24{cfg_q.match_score[7]}}, cfg_q.match_score};
      lao_pkg::REG_MISMATCH: prdata = {{24{cfg_q.mismatch_score[7]}}, cfg_q.mismatch_score};
      lao_pkg::REG_GAP:      prdata = {{24{cfg_q.gap_score[7]}}, cfg_q.gap_score};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_score    <= lao_pkg::MatchReset;
      cfg_q.mismatch_score <= lao_pkg::MismatchReset;
      cfg_q.gap_score      <= lao_pkg::GapReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lao_pkg::REG_MATCH:    cfg_q.match_score    <= pwdata[7:0];
        lao_pkg::REG_MISMATCH: cfg_q.mismatch_score <= pwdata[7:0];
        lao_pkg::REG_GAP:      cfg_q.gap_score      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lao_pkg::ST_IDLE: begin
        if (accept && (req_i.operation == lao_pkg::OP_ALIGN)) begin
          state_d = lao_pkg::ST_CLEAR;
        end
      end
      lao_pkg::ST_CLEAR: state_d = lao_pkg::ST_FILL;
      lao_pkg::ST_FILL: begin
        if (fc_q == len_sum) begin
          state_d = lao_pkg::ST_REDUCE;
        end
      end
      lao_pkg::ST_REDUCE: begin
        if (rc_q == RW'(MAX_LEN)) begin
          state_d = lao_pkg::ST_TRACE_RD;
        end
      end
      lao_pkg::ST_TRACE_RD: begin
        if ((ti_q == '0) || (tj_q == '0)) begin
          state_d = lao_pkg::ST_DONE;
        end else begin
          state_d = lao_pkg::ST_TRACE_ST;
        end
      end
      lao_pkg::ST_TRACE_ST: state_d = lao_pkg::ST_TRACE_RD;
      lao_pkg::ST_DONE:     state_d = lao_pkg::ST_IDLE;
      default:              state_d = lao_pkg::ST_IDLE;
    endcase
  end

  // outputs and control
  always_comb begin
    busy       = (state_q != lao_pkg::ST_IDLE);
    done_o     = (state_q == lao_pkg::ST_DONE);
    ctl.load   = accept && (req_i.operation == lao_pkg::OP_APPEND_SECOND)
                 && (len2_q < RW'(MAX_LEN));
    ctl.clear  = (state_q == lao_pkg::ST_CLEAR);
    ctl.fill   = (state_q == lao_pkg::ST_FILL);
    ctl.reduce = (state_q == lao_pkg::ST_REDUCE);
    first_we   = accept && (req_i.operation == lao_pkg::OP_APPEND_FIRST)
                 && (len1_q < RW'(MAX_LEN));
    // anti-diagonal d of the grid lands in the chain outputs when the fill count is d
    dir_we     = ctl.fill && (fc_q >= AW'(2)) && (fc_q <= len_sum);
  end

  assign tj_m1    = tj_q - RW'(1);
  assign step_dir = lao_pkg::dir_e'(dir_rd[{tj_m1[IW-1:0], 1'b0} +: 2]);

  always_comb begin
    len1_d  = len1_q;
    len2_d  = len2_q;
    drop_d  = drop_q;
    fc_d    = fc_q;
    rc_d    = rc_q;
    ti_d    = ti_q;
    tj_d    = tj_q;
    best_d  = best_q;
    inj_v_d = ctl.fill && (fc_q < AW'(len1_q));
    inj_r_d = fc_q[RW-1:0] + RW'(1);
    unique case (state_q)
      lao_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_i.operation)
            lao_pkg::OP_APPEND_FIRST: begin
              if (len1_q < RW'(MAX_LEN)) begin
                len1_d = len1_q + RW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            lao_pkg::OP_APPEND_SECOND: begin
              if (len2_q < RW'(MAX_LEN)) begin
                len2_d = len2_q + RW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      lao_pkg::ST_CLEAR: fc_d = '0;
      lao_pkg::ST_FILL: begin
        fc_d = fc_q + AW'(1);
        rc_d = '0;
      end
      lao_pkg::ST_REDUCE: begin
        rc_d   = rc_q + RW'(1);
        ti_d   = cr_w[MAX_LEN];
        tj_d   = cc_w[MAX_LEN];
        best_d = cs_w[MAX_LEN];
      end
      lao_pkg::ST_TRACE_ST: begin
        unique case (step_dir)
          lao_pkg::DIR_LEFT: ti_d = ti_q - RW'(1);
          lao_pkg::DIR_UP:   tj_d = tj_q - RW'(1);
          default: begin
            ti_d = ti_q - RW'(1);
            tj_d = tj_q - RW'(1);
          end
        endcase
      end
      lao_pkg::ST_DONE: begin
        len1_d = '0;
        len2_d = '0;
        drop_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lao_pkg::ST_IDLE;
      len1_q  <= '0;
      len2_q  <= '0;
      drop_q  <= 1'b0;
      fc_q    <= '0;
      rc_q    <= '0;
      inj_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len1_q  <= len1_d;
      len2_q  <= len2_d;
      drop_q  <= drop_d;
      fc_q    <= fc_d;
      rc_q    <= rc_d;
      inj_v_q <= inj_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inj_r_q <= inj_r_d;
    ti_q    <= ti_d;
    tj_q    <= tj_d;
    best_q  <= best_d;
  end

  assign res_o.best_score  = best_q;
  assign res_o.orientation = (ti_q < tj_q) ? lao_pkg::ORIENT_NEG :
                             ((ti_q == tj_q) ? lao_pkg::ORIENT_ZERO : lao_pkg::ORIENT_POS);
  assign res_o.truncated   = drop_q;

  lao_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (MAX_LEN)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (first_we),
    .waddr_i (len1_q[IW-1:0]),
    .wdata_i (sym_in),
    .raddr_i (fc_q[IW-1:0]),
    .rdata_o (first_rd)
  );

  lao_ram #(
    .WIDTH (DW),
    .DEPTH (2 * MAX_LEN + 1)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (fc_q),
    .wdata_i (dir_row),
    .raddr_i (AW'(ti_q) + AW'(tj_q)),
    .rdata_o (dir_rd)
  );

  // chain head: first-read symbols enter with their row, boundary scores are zero
  assign a_w[0]  = first_rd;
  assign v_w[0]  = inj_v_q;
  assign r_w[0]  = inj_r_q;
  assign h_w[0]  = '0;
  assign dg_w[0] = '0;
  assign cv_w[0] = 1'b0;
  assign cs_w[0] = '0;
  assign cr_w[0] = '0;
  assign cc_w[0] = '0;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lao_cell #(
      .SYMBOL_BITS (SYMBOL_BITS),
      .ROW_W       (RW),
      .COL         (k + 1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .cfg_i  (cfg_q),
      .len_i  (len2_q),
      .sym_i  (sym_in),
      .a_i    (a_w[k]),
      .v_i    (v_w[k]),
      .r_i    (r_w[k]),
      .h_i    (h_w[k]),
      .dg_i   (dg_w[k]),
      .cv_i   (cv_w[k]),
      .cs_i   (cs_w[k]),
      .cr_i   (cr_w[k]),
      .cc_i   (cc_w[k]),
      .a_o    (a_w[k+1]),
      .v_o    (v_w[k+1]),
      .r_o    (r_w[k+1]),
      .h_o    (h_w[k+1]),
      .dg_o   (dg_w[k+1]),
      .cv_o   (cv_w[k+1]),
      .cs_o   (cs_w[k+1]),
      .cr_o   (cr_w[k+1]),
      .cc_o   (cc_w[k+1]),
      .dir_o  (dir_row[2*k +: 2])
    );
  end

endmodule

`default_nettype wire

>>> rtl/lao_checker.sv
// port-level checks on the local alignment orientation block, bound to the top
// uses lao_pkg and local_alignment_orientation_macros.svh
`default_nettype none
`include "local_alignment_orientation_macros.svh"

module lao_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_i,
  input wire lao_pkg::req_t req_i,
  input wire logic          done_i,
  input wire lao_pkg::res_t res_i
);

  logic align_req;
  assign align_req = start_i && !busy_i && (req_i.operation == lao_pkg::OP_ALIGN);

  `LAO_ASSERT_NOW(a_done_busy, clk_i, rst_ni, done_i, busy_i)
  `LAO_ASSERT_NEXT(a_align_busy, clk_i, rst_ni, align_req, busy_i && !done_i)
  `LAO_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_i, !done_i && !busy_i)
  `LAO_ASSERT_NOW(a_orient_code, clk_i, rst_ni, done_i, res_i.orientation != 2'd3)
  `LAO_ASSERT_NOW(a_busy_fall, clk_i, rst_ni, $fell(busy_i), $past(done_i))

endmodule

bind local_alignment_orientation lao_checker u_lao_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start),
  .busy_i (busy),
  .req_i  (req_i),
  .done_i (done_o),
  .res_i  (res_o)
);

`default_nettype wire
